// ===== design/vcd_pkg.sv =====
// shared types and constants of the velocity command deframer
// no dependencies; imported by every module of the block
package vcd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_FIRST  = 3'd0,
    CFG_SYNC_SECOND = 3'd1,
    CFG_FRAME_KIND  = 3'd2,
    CFG_END_MARKER  = 3'd3,
    CFG_TIMEOUT_MS  = 3'd4
  } cfg_idx_e;

  localparam logic [7:0]  SyncFirstRst  = 8'd170;
  localparam logic [7:0]  SyncSecondRst = 8'd85;
  localparam logic [7:0]  FrameKindRst  = 8'd1;
  localparam logic [7:0]  EndMarkerRst  = 8'd13;
  localparam logic [15:0] TimeoutMsRst  = 16'd500;

  // frame layout: slots 0..11 ahead of the closing byte
  localparam logic [3:0] PosData   = 4'd3;
  localparam logic [3:0] PosSum    = 4'd11;
  localparam logic [3:0] PosSlots  = 4'd12;

  localparam logic [15:0] ElapsedMax = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HEAD0 = 3'd0,
    PH_HEAD1 = 3'd1,
    PH_TYPE  = 3'd2,
    PH_DATA  = 3'd3,
    PH_TAIL  = 3'd4
  } phase_e;

  typedef enum logic {
    EV_FRAME = 1'b0,
    EV_STOP  = 1'b1
  } event_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  frame_kind;
    logic [7:0]  end_marker;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic        event_res;
    logic [31:0] linear_bits;
    logic [31:0] angular_bits;
  } res_t;

endpackage

// ===== design/vcd_cfg.sv =====
// configuration register file of the velocity command deframer
// depends on vcd_pkg
module vcd_cfg import vcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SYNC_FIRST:  cfg_d.sync_first  = cfg_data_i[7:0];
        CFG_SYNC_SECOND: cfg_d.sync_second = cfg_data_i[7:0];
        CFG_FRAME_KIND:  cfg_d.frame_kind  = cfg_data_i[7:0];
        CFG_END_MARKER:  cfg_d.end_marker  = cfg_data_i[7:0];
        CFG_TIMEOUT_MS:  cfg_d.timeout_ms  = cfg_data_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SyncFirstRst;
      cfg_q.sync_second <= SyncSecondRst;
      cfg_q.frame_kind  <= FrameKindRst;
      cfg_q.end_marker  <= EndMarkerRst;
      cfg_q.timeout_ms  <= TimeoutMsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/vcd_parser.sv =====
// frame parser: header/type match, running xor checksum, data word shift register
// depends on vcd_pkg
module vcd_parser import vcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  rx_byte_i,
  input  cfg_t        cfg_i,
  output logic        frame_ok_o,
  output logic [31:0] linear_o,
  output logic [31:0] angular_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [3:0]  pos_inc;
  logic [7:0]  xor_q, xor_d;
  logic [63:0] data_q, data_d;

  assign pos_inc = pos_q + 4'd1;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    xor_d   = xor_q;
    data_d  = data_q;
    if (step_i) begin
      unique case (phase_q)
        PH_HEAD0: begin
          if (rx_byte_i == cfg_i.sync_first) begin
            xor_d   = rx_byte_i;
            pos_d   = 4'd1;
            phase_d = PH_HEAD1;
          end
        end
        PH_HEAD1: begin
          if (rx_byte_i == cfg_i.sync_second) begin
            xor_d   = xor_q ^ rx_byte_i;
            pos_d   = 4'd2;
            phase_d = PH_TYPE;
          end else begin
            phase_d = PH_HEAD0;
          end
        end
        PH_TYPE: begin
          if (rx_byte_i == cfg_i.frame_kind) begin
            xor_d   = xor_q ^ rx_byte_i;
            pos_d   = PosData;
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_HEAD0;
          end
        end
        PH_DATA: begin
          xor_d = xor_q ^ rx_byte_i;
          // checksum byte only goes into the xor, data bytes shift in from the top
          if (pos_q < PosSum) data_d = {rx_byte_i, data_q[63:8]};
          pos_d = pos_inc;
          if (pos_inc >= PosSlots || pos_inc < PosData) phase_d = PH_TAIL;
        end
        PH_TAIL: begin
          phase_d = PH_HEAD0;
          pos_d   = 4'd0;
        end
        default: begin
          phase_d = PH_HEAD0;
          pos_d   = 4'd0;
        end
      endcase
    end
  end

  // xor over all twelve slots is zero when the checksum matches
  always_comb begin
    frame_ok_o = step_i && (phase_q == PH_TAIL) && (rx_byte_i == cfg_i.end_marker)
                 && (xor_q == 8'd0);
  end

  assign linear_o  = data_q[31:0];
  assign angular_o = data_q[63:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD0;
      pos_q   <= 4'd0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xor_q  <= xor_d;
    data_q <= data_d;
  end

endmodule

// ===== design/vcd_watchdog.sv =====
// command watchdog: saturating millisecond counter and one-shot stop
// depends on vcd_pkg
module vcd_watchdog import vcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_i,
  input  logic        frame_ok_i,
  input  logic [15:0] timeout_ms_i,
  output logic        stop_o
);

  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] elapsed_inc;
  logic        stopped_q, stopped_d;
  logic        fire;

  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 16'd1;
  assign fire        = tick_i && (elapsed_inc > timeout_ms_i) && !stopped_q;

  always_comb begin
    elapsed_d = elapsed_q;
    stopped_d = stopped_q;
    if (tick_i) begin
      elapsed_d = elapsed_inc;
      if (fire) stopped_d = 1'b1;
    end else if (frame_ok_i) begin
      elapsed_d = 16'd0;
      stopped_d = 1'b0;
    end
  end

  assign stop_o = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= 16'd0;
      stopped_q <= 1'b0;
    end else begin
      elapsed_q <= elapsed_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

// ===== design/vcd_out_buf.sv =====
// result register with a skid entry behind it
// depends on vcd_pkg
module vcd_out_buf import vcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  res_t res_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // no new result arrives while the skid entry is held
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res_i;
        out_valid_d = res_valid_i;
      end
    end else if (res_valid_i) begin
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== design/velocity_command_deframer.sv =====
// velocity command deframer: byte stream frame parser plus millisecond watchdog
// a result is registered in the result register, or in the skid entry while the output stalls
// throughput: one item per cycle while the input is not stalled; parser, checksum and watchdog finish in that cycle
// a result register and one skid entry hold results; input stalls only when both are full
// reset (asynchronous, active low) restores register defaults, hunting state and idle watchdog
// depends on vcd_pkg, vcd_cfg, vcd_parser, vcd_watchdog, vcd_out_buf
module velocity_command_deframer import vcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                event_res_o,
  output logic [31:0]         linear_bits_o,
  output logic [31:0]         angular_bits_o
);

  cfg_t        cfg;
  logic        accept;
  logic        byte_step;
  logic        tick;
  logic        frame_ok;
  logic        stop;
  logic [31:0] linear;
  logic [31:0] angular;
  logic        buf_full;
  logic        res_valid;
  res_t        res;
  res_t        out_res;

  assign accept    = in_valid_i && !in_stall_o;
  assign byte_step = accept && !command_i;
  assign tick      = accept && command_i;
  assign in_stall_o = buf_full;

  vcd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  vcd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (byte_step),
    .rx_byte_i  (rx_byte_i),
    .cfg_i      (cfg),
    .frame_ok_o (frame_ok),
    .linear_o   (linear),
    .angular_o  (angular)
  );

  vcd_watchdog u_watchdog (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .frame_ok_i   (frame_ok),
    .timeout_ms_i (cfg.timeout_ms),
    .stop_o       (stop)
  );

  always_comb begin
    res_valid = frame_ok || stop;
    if (stop) begin
      res.event_res    = EV_STOP;
      res.linear_bits  = 32'd0;
      res.angular_bits = 32'd0;
    end else begin
      res.event_res    = EV_FRAME;
      res.linear_bits  = linear;
      res.angular_bits = angular;
    end
  end

  vcd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign event_res_o    = out_res.event_res;
  assign linear_bits_o  = out_res.linear_bits;
  assign angular_bits_o = out_res.angular_bits;

endmodule

// ===== tb/sv/tb.sv =====
// testbench of velocity_command_deframer: frame recognition, silent drops and tick watchdog
// results are checked against an in-bench deframer predictor; depends on vcd_pkg and the design
module tb;
  import vcd_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int RandomItems = 1000;
  localparam int HoldCycles  = 200;

  typedef enum logic [2:0] {
    FR_GOOD,
    FR_BAD_HEAD,
    FR_BAD_KIND,
    FR_BAD_SUM,
    FR_BAD_TAIL
  } frame_fault_e;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  cfg_idx_e            cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                command;
  logic [7:0]          rx_byte;
  logic                out_valid;
  logic                out_stall;
  logic                event_res;
  logic [31:0]         linear_bits;
  logic [31:0]         angular_bits;

  velocity_command_deframer u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .event_res_o    (event_res),
    .linear_bits_o  (linear_bits),
    .angular_bits_o (angular_bits)
  );

  // deframer predictor state
  cfg_t        regs = '{SyncFirstRst, SyncSecondRst, FrameKindRst, EndMarkerRst, TimeoutMsRst};
  phase_e      phase = PH_HEAD0;
  logic [3:0]  slot = '0;
  logic [7:0]  frame_bytes [12] = '{default: 8'h00};
  logic [15:0] ms_elapsed = '0;
  logic        stop_sent = 1'b0;
  res_t        issued_cmds [$];

  int fault_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;
  bit hold_req    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void flag(input string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endfunction

  function automatic void advance_deframer(input logic cmd, input logic [7:0] b);
    logic [7:0] sum;
    res_t       cmd_out;
    sum = '0;
    if (cmd) begin
      if (ms_elapsed != ElapsedMax) ms_elapsed++;
      if (ms_elapsed > regs.timeout_ms && !stop_sent) begin
        stop_sent = 1'b1;
        cmd_out.event_res    = EV_STOP;
        cmd_out.linear_bits  = '0;
        cmd_out.angular_bits = '0;
        issued_cmds.push_back(cmd_out);
      end
    end else begin
      case (phase)
        PH_HEAD0: begin
          if (b == regs.sync_first) begin
            frame_bytes[0] = b;
            slot = 4'd1;
            phase = PH_HEAD1;
          end
        end
        PH_HEAD1: begin
          if (b == regs.sync_second) begin
            frame_bytes[1] = b;
            slot = 4'd2;
            phase = PH_TYPE;
          end else begin
            phase = PH_HEAD0;
          end
        end
        PH_TYPE: begin
          if (b == regs.frame_kind) begin
            frame_bytes[2] = b;
            slot = PosData;
            phase = PH_DATA;
          end else begin
            phase = PH_HEAD0;
          end
        end
        PH_DATA: begin
          if (slot < PosSlots) frame_bytes[slot] = b;
          slot = slot + 4'd1;
          if (slot >= PosSlots || slot < PosData) phase = PH_TAIL;
        end
        PH_TAIL: begin
          phase = PH_HEAD0;
          slot = '0;
          for (int i = 0; i < PosSum; i++) sum ^= frame_bytes[i];
          if (b == regs.end_marker && sum == frame_bytes[PosSum]) begin
            ms_elapsed = '0;
            stop_sent = 1'b0;
            cmd_out.event_res    = EV_FRAME;
            cmd_out.linear_bits  = {frame_bytes[6], frame_bytes[5], frame_bytes[4], frame_bytes[3]};
            cmd_out.angular_bits = {frame_bytes[10], frame_bytes[9], frame_bytes[8], frame_bytes[7]};
            issued_cmds.push_back(cmd_out);
          end
        end
        default: begin
          phase = PH_HEAD0;
          slot = '0;
        end
      endcase
    end
  endfunction

  // sender: bursts of random length separated by random gaps unless held steady
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    gap = 0;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= cmd;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    advance_deframer(cmd, b);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic send_frame(input logic [31:0] lin, input logic [31:0] ang,
                            input frame_fault_e fault, input int tick_pct);
    logic [7:0] fr [13];
    fr[0] = regs.sync_first;
    fr[1] = regs.sync_second;
    fr[2] = regs.frame_kind;
    for (int i = 0; i < 4; i++) begin
      fr[3 + i] = lin[8 * i +: 8];
      fr[7 + i] = ang[8 * i +: 8];
    end
    fr[11] = '0;
    for (int i = 0; i < 11; i++) fr[11] ^= fr[i];
    fr[12] = regs.end_marker;
    case (fault)
      FR_BAD_HEAD: fr[1]  ^= 8'($urandom_range(1, 255));
      FR_BAD_KIND: fr[2]  ^= 8'($urandom_range(1, 255));
      FR_BAD_SUM:  fr[11] ^= 8'($urandom_range(1, 255));
      FR_BAD_TAIL: fr[12] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    for (int i = 0; i < 13; i++) begin
      // ticks may land anywhere inside a frame
      if (tick_pct > 0 && $urandom_range(0, 99) < tick_pct) send_tick();
      send_item(1'b0, fr[i]);
    end
  endtask

  // wait until every predicted command came out and nothing is left in flight
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (issued_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SYNC_FIRST:  regs.sync_first  = val[7:0];
      CFG_SYNC_SECOND: regs.sync_second = val[7:0];
      CFG_FRAME_KIND:  regs.frame_kind  = val[7:0];
      CFG_END_MARKER:  regs.end_marker  = val[7:0];
      CFG_TIMEOUT_MS:  regs.timeout_ms  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits of the byte registers carry junk that must be ignored
  task automatic program_regs(input logic [7:0] sf, input logic [7:0] ss, input logic [7:0] fk,
                              input logic [7:0] em, input logic [15:0] tmo);
    settle();
    write_reg(CFG_SYNC_FIRST,  {8'($urandom), sf});
    write_reg(CFG_SYNC_SECOND, {8'($urandom), ss});
    write_reg(CFG_FRAME_KIND,  {8'($urandom), fk});
    write_reg(CFG_END_MARKER,  {8'($urandom), em});
    write_reg(CFG_TIMEOUT_MS,  tmo);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_default_frames();
    send_frame(32'h0000_0000, 32'hFFFF_FFFF, FR_GOOD, 0);
    send_frame(32'hFFFF_FFFF, 32'h0000_0000, FR_GOOD, 40);
  endtask

  task automatic test_header_faults();
    // a repeated first header byte is not taken as a fresh start
    send_item(1'b0, regs.sync_first);
    send_item(1'b0, regs.sync_first);
    send_item(1'b0, regs.sync_second);
    send_item(1'b0, regs.sync_first);
    send_item(1'b0, regs.sync_second);
    send_item(1'b0, regs.frame_kind ^ 8'h01);
    send_frame(random_word(), random_word(), FR_GOOD, 0);
  endtask

  task automatic test_frame_drops();
    send_frame(random_word(), random_word(), FR_BAD_SUM, 0);
    send_frame(random_word(), random_word(), FR_BAD_TAIL, 0);
    send_frame(random_word(), random_word(), FR_GOOD, 0);
  endtask

  task automatic test_watchdog();
    program_regs(SyncFirstRst, SyncSecondRst, FrameKindRst, EndMarkerRst, 16'd2);
    repeat (5) send_tick();
    send_frame(random_word(), random_word(), FR_GOOD, 0);
    repeat (4) send_tick();
  endtask

  task automatic test_watchdog_long_timeout();
    program_regs(SyncFirstRst, SyncSecondRst, FrameKindRst, EndMarkerRst, 16'd65534);
    steady = 1'b1;
    send_frame(random_word(), random_word(), FR_GOOD, 0);
    // far below the limit, so no stop may come out
    repeat (40) send_tick();
    send_frame(random_word(), random_word(), FR_GOOD, 0);
    steady = 1'b0;
    program_regs(SyncFirstRst, SyncSecondRst, FrameKindRst, EndMarkerRst, 16'd1);
    repeat (3) send_tick();
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_req = 1'b1;
    repeat (8) send_frame(random_word(), random_word(), FR_GOOD, 0);
    steady = 1'b0;
  endtask

  task automatic run_traffic(input int budget, input int max_ticks);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(random_word(), random_word(), FR_GOOD, 5);
      end else if (pick < 75) begin
        send_frame(random_word(), random_word(), frame_fault_e'($urandom_range(1, 4)), 5);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, max_ticks)) send_tick();
      end else begin
        repeat ($urandom_range(1, 6)) send_item(1'b0, 8'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [7:0] same;
    same = 8'($urandom);
    program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom_range(1, 40)));
    run_traffic(RandomItems / 4, 30);
    program_regs(8'h00, 8'hFF, 8'h00, 8'hFF, 16'd1);
    steady = 1'b1;
    run_traffic(RandomItems / 4, 4);
    steady = 1'b0;
    program_regs(8'hFF, 8'h00, 8'hFF, 8'h00, 16'd65534);
    run_traffic(RandomItems / 4, 30);
    // both header bytes equal
    program_regs(same, same, 8'($urandom), 8'($urandom), 16'($urandom_range(1, 20)));
    run_traffic(RandomItems / 4, 20);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SYNC_FIRST;
    cfg_data  = '0;
    in_valid  = 1'b0;
    command   = 1'b0;
    rx_byte   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_frames();
    test_header_faults();
    test_frame_drops();
    test_watchdog();
    test_watchdog_long_timeout();
    test_backpressure();
    test_random_traffic();
    settle();
    if (issued_cmds.size() != 0) flag($sformatf("%0d commands never issued", issued_cmds.size()));
    if (fault_count == 0) begin
      $display("velocity_command_deframer test passed");
    end else begin
      $display("velocity_command_deframer test failed");
    end
    $finish;
  end

  // receiver: stall pattern switches among four modes at random, plus one long hold-off on request
  initial begin
    int mode;
    int left;
    int phase_cnt;
    mode = 0;
    left = 0;
    phase_cnt = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 300);
        end
        left--;
        phase_cnt++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= phase_cnt[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (issued_cmds.size() == 0) begin
        flag($sformatf("unexpected command: ev=%0d lin=%h ang=%h",
                       event_res, linear_bits, angular_bits));
      end else begin
        want = issued_cmds.pop_front();
        if (event_res !== want.event_res || linear_bits !== want.linear_bits ||
            angular_bits !== want.angular_bits) begin
          flag($sformatf("command mismatch: expected ev=%0d lin=%h ang=%h, got ev=%0d lin=%h ang=%h",
                         want.event_res, want.linear_bits, want.angular_bits,
                         event_res, linear_bits, angular_bits));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("no item moved for %0d cycles", StallLimit);
      $display("velocity_command_deframer test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
